### src/ftjt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ftjt_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int TIME_WIDTH  = 48;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W       = 104;
	localparam logic [31:0] TIMEOUT_RESET = 32'd30000000;

	typedef enum logic [1:0] {
		ST_UPDATED = 2'd0,
		ST_NEW     = 2'd1,
		ST_FULL    = 2'd2,
		ST_NEG     = 2'd3
	} status_t;

	// one table row, all per-slot stores side by side
	typedef struct packed {
		logic [KEY_W-1:0]      key;
		logic                  active;
		logic [TIME_WIDTH-1:0] last;
		logic [31:0]           lint;
		logic [31:0]           cnt;
		logic [47:0]           isum;
		logic [31:0]           imax;
		logic [47:0]           vsum;
		logic [35:0]           jit;
		logic [35:0]           jmax;
	} row_t;

	typedef struct packed {
		logic       load_in;
		logic       sweep;
		logic       search;
		logic       restart;
		logic [4:0] calc;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic search_done;
		logic hit;
		logic out_busy;
	} stat_t;

endpackage
`default_nettype wire

### src/flow_table_jitter_tracker_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// five-tuple flow tracker with inter-arrival statistics and ewma jitter
// input channel: in_valid / in_stall, one packet key and timestamp per transfer
// output channel: out_valid / out_stall, one result per packet, held in an
//   output register so the next packet may enter while a result waits
// config: cfg_wr_en / cfg_wr_data write the idle timeout in microseconds;
//   write it only while the block is idle, as the block does not enforce this
// per packet: capture of the packet, an expiry sweep over the entries below
//   the high-water mark of the table, a match and free-slot search over the
//   same entries that stops at a hit, the arithmetic states S_C1 to S_C5 for
//   a hit, and the write-back of the entry together with the load of the
//   result register
// the packet rate is bound by the single read port of the table memory,
//   which both passes walk one entry a cycle
// in_stall is high from the transfer of a packet until its result has been
//   loaded into the output register; a stalled result holds that load off
// reset clears the high-water mark and control state and restores the
//   default timeout; entries above the mark are never read, so the table
//   itself needs no clearing pass
module flow_table_jitter_tracker_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [31:0]                     cfg_wr_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [31:0]                     source_address,
	input  wire logic [31:0]                     dest_address,
	input  wire logic [15:0]                     source_port,
	input  wire logic [15:0]                     dest_port,
	input  wire logic [7:0]                      proto_number,
	input  wire logic [ftjt_pkg::TIME_WIDTH-1:0] arrive_us,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic      [ftjt_pkg::IDX_W-1:0]      slot,
	output logic      [1:0]                      status,
	output logic      [31:0]                     pkt_total,
	output logic      [31:0]                     interval,
	output logic      [31:0]                     variation,
	output logic      [35:0]                     jitter,
	output logic      [31:0]                     ivl_peak,
	output logic      [35:0]                     jit_peak,
	output logic      [47:0]                     ivl_total,
	output logic      [47:0]                     var_total,
	output logic      [ftjt_pkg::CNT_W-1:0]      expired_count
);

	// command and status between sequencer and datapath
	ftjt_pkg::cmd_t  cmd;
	ftjt_pkg::stat_t st;

	ftjt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.st      (st),
		.cmd     (cmd)
	);

	// table memory, sweep and search walk, statistics arithmetic, result register
	ftjt_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.source_address (source_address),
		.dest_address   (dest_address),
		.source_port    (source_port),
		.dest_port      (dest_port),
		.proto_number   (proto_number),
		.arrive_us      (arrive_us),
		.cmd            (cmd),
		.st             (st),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.slot           (slot),
		.status         (status),
		.pkt_total      (pkt_total),
		.interval       (interval),
		.variation      (variation),
		.jitter         (jitter),
		.ivl_peak       (ivl_peak),
		.jit_peak       (jit_peak),
		.ivl_total      (ivl_total),
		.var_total      (var_total),
		.expired_count  (expired_count)
	);

endmodule
`default_nettype wire

### src/ftjt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ftjt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### src/ftjt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ftjt_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire ftjt_pkg::stat_t st,
	output ftjt_pkg::cmd_t      cmd
);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_SWEEP  = 9'b000000010,
		S_SEARCH = 9'b000000100,
		S_C1     = 9'b000001000,
		S_C2     = 9'b000010000,
		S_C3     = 9'b000100000,
		S_C4     = 9'b001000000,
		S_C5     = 9'b010000000,
		S_FINISH = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_SWEEP;
				end
			end
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (st.scan_done) begin
					cmd.restart = 1'b1;
					state_d     = S_SEARCH;
				end
			end
			S_SEARCH: begin
				cmd.search = 1'b1;
				if (st.search_done) begin
					state_d = st.hit ? S_C1 : S_FINISH;
				end
			end
			S_C1: begin
				cmd.calc[0] = 1'b1;
				state_d     = S_C2;
			end
			S_C2: begin
				cmd.calc[1] = 1'b1;
				state_d     = S_C3;
			end
			S_C3: begin
				cmd.calc[2] = 1'b1;
				state_d     = S_C4;
			end
			S_C4: begin
				cmd.calc[3] = 1'b1;
				state_d     = S_C5;
			end
			S_C5: begin
				cmd.calc[4] = 1'b1;
				state_d     = S_FINISH;
			end
			S_FINISH: begin
				if (!st.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

### src/ftjt_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module ftjt_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [31:0]                       cfg_wr_data,
	input  wire logic [31:0]                       source_address,
	input  wire logic [31:0]                       dest_address,
	input  wire logic [15:0]                       source_port,
	input  wire logic [15:0]                       dest_port,
	input  wire logic [7:0]                        proto_number,
	input  wire logic [ftjt_pkg::TIME_WIDTH-1:0]   arrive_us,
	input  wire ftjt_pkg::cmd_t                    cmd,
	output ftjt_pkg::stat_t                        st,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [ftjt_pkg::IDX_W-1:0]        slot,
	output logic      [1:0]                        status,
	output logic      [31:0]                       pkt_total,
	output logic      [31:0]                       interval,
	output logic      [31:0]                       variation,
	output logic      [35:0]                       jitter,
	output logic      [31:0]                       ivl_peak,
	output logic      [35:0]                       jit_peak,
	output logic      [47:0]                       ivl_total,
	output logic      [47:0]                       var_total,
	output logic      [ftjt_pkg::CNT_W-1:0]        expired_count
);

	localparam int TW = ftjt_pkg::TIME_WIDTH;
	localparam int IW = ftjt_pkg::IDX_W;
	localparam int CW = ftjt_pkg::CNT_W;

	logic [31:0]               timeout_q;
	logic [ftjt_pkg::KEY_W-1:0] key_q;
	logic [TW-1:0]             now_q;
	logic [CW-1:0]             used_q, rd_idx_q, exp_q;
	logic                      pend_s1;
	logic [IW-1:0]             pend_idx_s1;
	logic                      hit_q, free_q;
	logic [IW-1:0]             hit_idx_q, free_idx_q;
	ftjt_pkg::row_t            hrow_q, rdata, wdata, new_row, upd_row;
	logic                      issue, expire, match, take_free, we;
	logic [IW-1:0]             waddr;
	logic [TW:0]               elapsed;

	// calculation registers
	logic        neg_q, third_q, up_q;
	logic [31:0] ivl_q, cnt_q, imax_q, var_q;
	logic [47:0] isum_q, vsum_q;
	logic [35:0] dj_q, jit_q, jmax_q;

	logic [TW:0]  diff;
	logic [48:0]  isum_sum, vsum_sum;
	logic [35:0]  v16;
	logic         out_valid_q;
	logic         is_new, grow;
	logic [IW-1:0] new_slot;

	assign issue = (cmd.sweep || (cmd.search && !hit_q)) && (rd_idx_q < used_q);

	ftjt_ram #(
		.WIDTH($bits(ftjt_pkg::row_t)),
		.DEPTH(ftjt_pkg::TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (issue),
		.raddr(rd_idx_q[IW-1:0]),
		.rdata(rdata)
	);

	// expiry check on the entry just read; entries stamped later than the packet never expire
	assign elapsed = {1'b0, now_q} - {1'b0, rdata.last};
	assign expire  = pend_s1 && cmd.sweep && rdata.active && !elapsed[TW] &&
		(elapsed[TW-1:0] > {{(TW-32){1'b0}}, timeout_q});
	assign match     = pend_s1 && cmd.search && !hit_q && rdata.active &&
		(rdata.key == key_q);
	assign take_free = pend_s1 && cmd.search && !hit_q && !rdata.active && !free_q;

	assign is_new   = !hit_q && (free_q || (used_q < CW'(ftjt_pkg::TABLE_DEPTH)));
	assign grow     = !hit_q && !free_q && (used_q < CW'(ftjt_pkg::TABLE_DEPTH));
	assign new_slot = free_q ? free_idx_q : used_q[IW-1:0];

	always_comb begin
		new_row        = '0;
		new_row.key    = key_q;
		new_row.active = 1'b1;
		new_row.last   = now_q;
		new_row.cnt    = 32'd1;
		upd_row        = hrow_q;
		upd_row.last   = now_q;
		upd_row.lint   = ivl_q;
		upd_row.cnt    = cnt_q;
		upd_row.isum   = isum_q;
		upd_row.imax   = imax_q;
		upd_row.vsum   = vsum_q;
		upd_row.jit    = jit_q;
		upd_row.jmax   = jmax_q;
		we    = 1'b0;
		waddr = pend_idx_s1;
		wdata = rdata;
		if (expire) begin
			we           = 1'b1;
			wdata.active = 1'b0;
		end else if (cmd.finish && hit_q && !neg_q) begin
			we    = 1'b1;
			waddr = hit_idx_q;
			wdata = upd_row;
		end else if (cmd.finish && is_new) begin
			we    = 1'b1;
			waddr = new_slot;
			wdata = new_row;
		end
	end

	assign diff     = {1'b0, now_q} - {1'b0, hrow_q.last};
	assign isum_sum = {1'b0, hrow_q.isum} + {17'd0, ivl_q};
	assign vsum_sum = {1'b0, hrow_q.vsum} + {17'd0, var_q};
	assign v16      = {var_q, 4'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= ftjt_pkg::TIMEOUT_RESET;
			used_q      <= '0;
			rd_idx_q    <= '0;
			exp_q       <= '0;
			pend_s1     <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				timeout_q <= cfg_wr_data;
			end
			// no read is issued in a load or restart cycle
			pend_s1 <= issue;
			if (issue) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
			if (cmd.load_in) begin
				rd_idx_q <= '0;
				exp_q    <= '0;
				hit_q    <= 1'b0;
				free_q   <= 1'b0;
			end
			if (cmd.restart) begin
				rd_idx_q <= '0;
			end
			if (expire) begin
				exp_q <= exp_q + CW'(1);
			end
			if (match) begin
				hit_q <= 1'b1;
			end
			if (take_free) begin
				free_q <= 1'b1;
			end
			if (cmd.finish && grow) begin
				used_q <= used_q + CW'(1);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		pend_idx_s1 <= rd_idx_q[IW-1:0];
		if (cmd.load_in) begin
			key_q <= {source_address, dest_address, source_port, dest_port, proto_number};
			now_q <= arrive_us;
		end
		if (match) begin
			hit_idx_q <= pend_idx_s1;
			hrow_q    <= rdata;
		end
		if (take_free) begin
			free_idx_q <= pend_idx_s1;
		end
		if (cmd.calc[0]) begin
			neg_q <= diff[TW];
			ivl_q <= (|diff[TW-1:32]) ? 32'hFFFF_FFFF : diff[31:0];
			cnt_q <= (&hrow_q.cnt) ? hrow_q.cnt : hrow_q.cnt + 32'd1;
		end
		if (cmd.calc[1]) begin
			isum_q  <= isum_sum[48] ? 48'hFFFF_FFFF_FFFF : isum_sum[47:0];
			imax_q  <= (ivl_q > hrow_q.imax) ? ivl_q : hrow_q.imax;
			third_q <= (cnt_q >= 32'd3);
			if (cnt_q >= 32'd3) begin
				var_q <= (ivl_q >= hrow_q.lint) ? ivl_q - hrow_q.lint : hrow_q.lint - ivl_q;
			end else begin
				var_q <= '0;
			end
		end
		if (cmd.calc[2]) begin
			if (third_q) begin
				vsum_q <= vsum_sum[48] ? 48'hFFFF_FFFF_FFFF : vsum_sum[47:0];
			end else begin
				vsum_q <= hrow_q.vsum;
			end
			up_q <= (v16 >= hrow_q.jit);
			dj_q <= (v16 >= hrow_q.jit) ? (v16 - hrow_q.jit) >> 4 : (hrow_q.jit - v16) >> 4;
		end
		if (cmd.calc[3]) begin
			if (third_q) begin
				jit_q <= up_q ? hrow_q.jit + dj_q : hrow_q.jit - dj_q;
			end else begin
				jit_q <= hrow_q.jit;
			end
		end
		if (cmd.calc[4]) begin
			jmax_q <= (jit_q > hrow_q.jmax) ? jit_q : hrow_q.jmax;
		end
		if (cmd.finish) begin
			expired_count <= exp_q;
			if (hit_q && neg_q) begin
				slot      <= hit_idx_q;
				status    <= ftjt_pkg::ST_NEG;
				pkt_total <= hrow_q.cnt;
				interval  <= '0;
				variation <= '0;
				jitter    <= hrow_q.jit;
				ivl_peak  <= hrow_q.imax;
				jit_peak  <= hrow_q.jmax;
				ivl_total <= hrow_q.isum;
				var_total <= hrow_q.vsum;
			end else if (hit_q) begin
				slot      <= hit_idx_q;
				status    <= ftjt_pkg::ST_UPDATED;
				pkt_total <= cnt_q;
				interval  <= ivl_q;
				variation <= var_q;
				jitter    <= jit_q;
				ivl_peak  <= imax_q;
				jit_peak  <= jmax_q;
				ivl_total <= isum_q;
				var_total <= vsum_q;
			end else begin
				slot      <= is_new ? new_slot : '0;
				status    <= is_new ? ftjt_pkg::ST_NEW : ftjt_pkg::ST_FULL;
				pkt_total <= is_new ? 32'd1 : 32'd0;
				interval  <= '0;
				variation <= '0;
				jitter    <= '0;
				ivl_peak  <= '0;
				jit_peak  <= '0;
				ivl_total <= '0;
				var_total <= '0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign st.scan_done   = (rd_idx_q == used_q) && !pend_s1;
	assign st.search_done = hit_q || ((rd_idx_q == used_q) && !pend_s1);
	assign st.hit         = hit_q;
	assign st.out_busy    = out_valid_q && out_stall;

endmodule
`default_nettype wire
